FILE: rtl/core/carm_pkg.sv
// Shared types and constants for the cascaded attitude rate mixer.
// No dependencies.
package carm_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 24;

    typedef enum logic [2:0] {
        t_cfg_angle_gain  = 3'd0,
        t_cfg_max_rate    = 3'd1,
        t_cfg_rate_kp     = 3'd2,
        t_cfg_rate_ki_dt  = 3'd3,
        t_cfg_rate_kd     = 3'd4,
        t_cfg_integ_limit = 3'd5,
        t_cfg_corr_limit  = 3'd6,
        t_cfg_motor_max   = 3'd7
    } t_cfg_index;

    // Minimum rate target magnitude, 0.02 rad/s in Q3.12.
    localparam logic [14:0] MinRateQ12 = 15'd82;

    typedef struct packed {
        logic signed [15:0] roll_error;
        logic signed [15:0] pitch_error;
        logic signed [15:0] gyro_roll_rate;
        logic signed [15:0] gyro_pitch_rate;
        logic [10:0]        base_throttle;
    } t_in_item;

    typedef struct packed {
        logic [10:0] motor_rear_left;
        logic [10:0] motor_front_left;
        logic [10:0] motor_rear_right;
        logic [10:0] motor_front_right;
    } t_out_item;

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_mag,     // |a|*|a|
        t_st_tgt,     // gain * a^2
        t_st_err,     // form rate error
        t_st_p,       // kp * err
        t_st_i,       // ki * err
        t_st_d,       // kd * (err - prev)
        t_st_sum,     // clamp correction
        t_st_mix,     // one motor a cycle
        t_st_out
    } t_state;

endpackage

FILE: rtl/core/carm_stream_if.sv
// Valid/ready channel carrying one payload item.
// Depends on nothing; payload type is a parameter.
interface carm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/carm_mul.sv
// Shared signed multiplier with registered product.
// Depends on nothing.
module carm_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [19:0] i_b,
    output logic signed [52:0] o_p
);
    logic signed [52:0] r_p;

    // Register one product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= 53'(i_a) * 53'(i_b);
    end

    assign o_p = r_p;
endmodule

FILE: rtl/core/cascaded_attitude_rate_mixer_top.sv
// Top level of the cascaded attitude rate mixer.
// Depends on carm_pkg, carm_stream_if and carm_mul.
//
// Usage:
//   s_in carries one item of two angle errors, two gyro rates and a base
//   throttle; m_out carries one item of four motor commands per input item.
//   Configuration registers are written through i_cfg_we/i_cfg_idx/
//   i_cfg_data while the block is idle; the user is bound to this, as the
//   block itself does not enforce it.
//   Each item runs through one shared multiplier under a sequencer: per axis
//   the rate target in two steps, the error in one, the three PID products
//   and the sum, then the mixing of the four motors, one per step.
//   s_in is not ready while an item is in work or while a result waits, so
//   the next item is taken after the result leaves.
//   If m_out stalls, the result holds and no new item is accepted.
//   Reset loads the register defaults and clears integrators, previous
//   errors and motor residues.
module cascaded_attitude_rate_mixer_top #(
    parameter int unsigned RESIDUE_FRACTION_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [carm_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [carm_pkg::CfgDataW-1:0]   i_cfg_data,
    carm_stream_if.sink   s_in,
    carm_stream_if.source m_out
);
    import carm_pkg::*;

    localparam int unsigned F   = RESIDUE_FRACTION_BITS;
    localparam int unsigned SPd = 20 - F;
    localparam int unsigned SI  = 36 - F;

    // Configuration registers
    logic [15:0] r_gain, r_kp, r_kd;
    logic [14:0] r_max_rate;
    logic [23:0] r_ki;
    logic [18:0] r_ilim, r_clim;
    logic [10:0] r_mmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= 16'd768;
            r_max_rate <= 15'd16384;
            r_kp       <= 16'd1536;
            r_ki       <= 24'd6711;
            r_kd       <= 16'd256;
            r_ilim     <= 19'd25600;
            r_clim     <= 19'd76800;
            r_mmax     <= 11'd1200;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_idx))
                t_cfg_angle_gain:  r_gain     <= i_cfg_data[15:0];
                t_cfg_max_rate:    r_max_rate <= i_cfg_data[14:0];
                t_cfg_rate_kp:     r_kp       <= i_cfg_data[15:0];
                t_cfg_rate_ki_dt:  r_ki       <= i_cfg_data;
                t_cfg_rate_kd:     r_kd       <= i_cfg_data[15:0];
                t_cfg_integ_limit: r_ilim     <= i_cfg_data[18:0];
                t_cfg_corr_limit:  r_clim     <= i_cfg_data[18:0];
                t_cfg_motor_max:   r_mmax     <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // State and datapath registers
    t_state r_st, n_st;
    logic   r_ax, n_ax;           // 0 roll, 1 pitch
    logic [1:0] r_mi, n_mi;
    t_in_item  r_in;
    t_out_item r_out;
    logic signed [20:0] r_integ [2];
    logic signed [17:0] r_prev  [2];
    logic [F-1:0]       r_res   [4];
    logic signed [16:0] r_a;          // negated angle error
    logic signed [17:0] r_err;
    logic signed [40:0] r_acc;        // p + i
    logic signed [19:0] r_corr [2];

    logic signed [32:0] w_ma;
    logic signed [19:0] w_mb;
    logic signed [52:0] w_p;

    carm_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_p));

    logic signed [16:0] w_angle, w_gyro;
    assign w_angle = r_ax ? -17'(r_in.pitch_error) : -17'(r_in.roll_error);
    assign w_gyro  = r_ax ? 17'(r_in.gyro_pitch_rate) : 17'(r_in.gyro_roll_rate);

    logic [16:0] w_amag;
    assign w_amag = w_angle[16] ? 17'(-w_angle) : 17'(w_angle);

    // Operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_st)
            t_st_mag: begin
                w_ma = 33'(signed'({1'b0, w_amag}));
                w_mb = 20'(signed'({1'b0, w_amag}));
            end
            t_st_tgt: begin
                w_ma = w_p[32:0];
                w_mb = 20'(signed'({1'b0, r_gain}));
            end
            t_st_p: begin
                w_ma = 33'(r_err);
                w_mb = 20'(signed'({1'b0, r_kp}));
            end
            t_st_i: begin
                w_ma = 33'(signed'({1'b0, r_ki}));
                w_mb = 20'(r_err);
            end
            t_st_d: begin
                w_ma = 33'(r_err) - 33'(r_prev[r_ax]);
                w_mb = 20'(signed'({1'b0, r_kd}));
            end
            default: ;
        endcase
    end

    // Target magnitude from the registered gain*a^2 product
    logic [52:0] w_tm;
    logic [14:0] w_tmag;
    always_comb begin
        w_tm = 53'(w_p >>> 20);
        if (w_tm < 53'(MinRateQ12)) w_tmag = MinRateQ12;
        else if (w_tm > 53'(r_max_rate)) w_tmag = r_max_rate;
        else w_tmag = w_tm[14:0];
        if (53'(MinRateQ12) > 53'(r_max_rate) && w_tm < 53'(MinRateQ12))
            w_tmag = r_max_rate;
    end

    // Integrator update
    logic signed [41:0] w_isum;
    logic signed [20:0] w_integ_n;
    always_comb begin
        w_isum = 42'(r_integ[r_ax]) + 42'(w_p >>> SI);
        if (w_isum > 42'(signed'({1'b0, r_ilim}))) w_integ_n = 21'(signed'({1'b0, r_ilim}));
        else if (w_isum < -42'(signed'({1'b0, r_ilim})))
            w_integ_n = -21'(signed'({1'b0, r_ilim}));
        else w_integ_n = w_isum[20:0];
    end

    // Add the derivative term, then clamp the correction
    logic signed [40:0] w_acc;
    logic signed [19:0] w_corr;
    always_comb begin
        w_acc = r_acc + 41'(w_p >>> SPd);
        if (w_acc > 41'(signed'({1'b0, r_clim}))) w_corr = 20'(signed'({1'b0, r_clim}));
        else if (w_acc < -41'(signed'({1'b0, r_clim}))) w_corr = -20'(signed'({1'b0, r_clim}));
        else w_corr = w_acc[19:0];
    end

    // Motor mix for motor r_mi: A=T-p+r, B=T+p+r, C=T-p-r, D=T+p-r
    logic signed [31:0] w_msum;
    logic [10:0]        w_mot;
    always_comb begin
        w_msum = 32'(signed'({1'b0, r_in.base_throttle})) <<< F;
        w_msum = r_mi[0] ? w_msum + 32'(r_corr[1]) : w_msum - 32'(r_corr[1]);
        w_msum = r_mi[1] ? w_msum - 32'(r_corr[0]) : w_msum + 32'(r_corr[0]);
        w_msum = w_msum + 32'(signed'({1'b0, r_res[r_mi]}));
        if (w_msum < 0) w_mot = '0;
        else if ((w_msum >>> F) > 32'(signed'({1'b0, r_mmax}))) w_mot = r_mmax;
        else w_mot = 11'(w_msum >>> F);
    end

    // Sequencer
    always_comb begin
        n_st = r_st;
        n_ax = r_ax;
        n_mi = r_mi;
        unique case (r_st)
            t_st_idle: if (s_in.valid) begin
                n_st = t_st_mag;
                n_ax = 1'b0;
            end
            t_st_mag: n_st = t_st_tgt;
            t_st_tgt: n_st = t_st_err;
            t_st_err: n_st = t_st_p;
            t_st_p:   n_st = t_st_i;
            t_st_i:   n_st = t_st_d;
            t_st_d:   n_st = t_st_sum;
            t_st_sum: begin
                n_st = t_st_mix;
                n_mi = 2'd0;
                if (!r_ax) begin
                    n_st = t_st_mag;
                    n_ax = 1'b1;
                end
            end
            t_st_mix: begin
                n_mi = r_mi + 2'd1;
                if (r_mi == 2'd3) n_st = t_st_out;
            end
            t_st_out: if (m_out.ready) n_st = t_st_idle;
            default: n_st = t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_st_idle;
            r_ax <= 1'b0;
            r_mi <= 2'd0;
            r_integ[0] <= '0;
            r_integ[1] <= '0;
            r_prev[0] <= '0;
            r_prev[1] <= '0;
            for (int k = 0; k < 4; k++) r_res[k] <= '0;
        end else begin
            r_st <= n_st;
            r_ax <= n_ax;
            r_mi <= n_mi;
            // Advance the per-item datapath
            case (r_st)
                t_st_idle: if (s_in.valid) r_in <= s_in.data;
                t_st_mag:  r_a <= w_angle;
                t_st_tgt:  ;
                t_st_err: begin
                    r_err <= 18'(r_a[16] ? -18'(w_tmag) : 18'(w_tmag)) + 18'(w_gyro);
                end
                t_st_p: ;
                t_st_i: r_acc <= 41'(w_p >>> SPd);
                t_st_d: begin
                    r_integ[r_ax] <= w_integ_n;
                    r_acc <= r_acc + 41'(w_integ_n);
                end
                t_st_sum: begin
                    r_prev[r_ax] <= r_err;
                    r_corr[r_ax] <= w_corr;
                end
                t_st_mix: begin
                    r_res[r_mi] <= (w_msum < 0) ? '0 : w_msum[F-1:0];
                    case (r_mi)
                        2'd0: r_out.motor_rear_left   <= w_mot;
                        2'd1: r_out.motor_front_left  <= w_mot;
                        2'd2: r_out.motor_rear_right  <= w_mot;
                        default: r_out.motor_front_right <= w_mot;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Take an item only when idle; offer the result in the output state
    assign s_in.ready  = (r_st == t_st_idle);
    assign m_out.valid = (r_st == t_st_out);
    assign m_out.data  = r_out;

endmodule
